// ----- design/interval_set_merge_table_defines.svh -----
// -----------------------------------------------------------------------------
// Interval set merge table assertion macros
// Shared property forms for the table's concurrent checks.
// -----------------------------------------------------------------------------
`ifndef INTERVAL_SET_MERGE_TABLE_DEFINES_SVH
`define INTERVAL_SET_MERGE_TABLE_DEFINES_SVH

// same-cycle implication
`define ISMS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("interval set merge table check failed");

// next-cycle implication
`define ISMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("interval set merge table check failed");

`endif

// ----- design/isms_pkg.sv -----
// -----------------------------------------------------------------------------
// Interval set merge table package
// Sizes, request and response types, entry layout and key conversion.
// -----------------------------------------------------------------------------
package isms_pkg;

   localparam int MAX_INTERVALS = 16;
   localparam int COORD_WIDTH   = 32;

   localparam int FIELD_W = 32;
   localparam int KIND_W  = 2;
   localparam int USED_W  = 5;
   localparam int IDX_W   = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
   localparam int CNT_W   = $clog2(MAX_INTERVALS + 1);
   localparam int ENTRY_W = 2 * COORD_WIDTH;

   localparam logic [KIND_W-1:0] KIND_INCLUDE    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_INTERSECTS = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CONTAINS   = 2'd2;

   typedef logic [COORD_WIDTH-1:0] key_type;
   typedef logic [IDX_W-1:0]       idx_type;
   typedef logic [CNT_W-1:0]       cnt_type;

   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic signed [FIELD_W-1:0] range_begin;
      logic signed [FIELD_W-1:0] range_end;
   } req_type;

   typedef struct packed {
      logic              answer;
      logic              status;
      logic [USED_W-1:0] entries_used;
   } rsp_type;

   typedef struct packed {
      key_type lo;
      key_type hi;
   } entry_type;

   typedef struct packed {
      logic lo_le_e;
      logic lo_le_b;
      logic hi_ge_b;
      logic hi_ge_e;
      logic lo_lt_nb;
      logic hi_gt_ne;
   } cmp_flags_type;

   localparam key_type KEY_SIGN = key_type'(1) << (COORD_WIDTH - 1);

   function automatic key_type to_key(input logic signed [FIELD_W-1:0] v);
      key_type k;
      k = key_type'(v);
      return k ^ KEY_SIGN;
   endfunction

endpackage

// ----- design/interval_set_merge_table.sv -----
// -----------------------------------------------------------------------------
// Interval set merge table: sorted disjoint interval store with merge/query
// Query: scans the stored entries in order, one stored entry compared per cycle.
// Include: a scan, then entries shifted up before the place or copied down after it.
// One request at a time; throughput set by the single table read port.
// Reset clears the entry count and control; table contents are not cleared.
// -----------------------------------------------------------------------------
`include "interval_set_merge_table_defines.svh"

module interval_set_merge_table import isms_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [6:0] {
      ST_IDLE       = 7'b0000001,
      ST_SCAN       = 7'b0000010,
      ST_SHIFT_PREP = 7'b0000100,
      ST_SHIFT      = 7'b0001000,
      ST_PLACE      = 7'b0010000,
      ST_COPY       = 7'b0100000,
      ST_RESP       = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   key_type           b_ff, b_in, e_ff, e_in, nb_ff, nb_in, ne_ff, ne_in;
   cnt_type           p_ff, p_in, k_ff, k_in, i_ff, i_in, s_ff, s_in;
   cnt_type           count_ff, count_in;
   logic              absorb_ff, absorb_in;
   logic              answer_ff, answer_in, status_ff, status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              wr_en;
   idx_type           wr_addr, rd_addr;
   logic [ENTRY_W-1:0] wr_data, rd_data;
   entry_type         entry;
   cmp_flags_type     flags;
   logic              at_end, absorb_now, rsp_load;
   cnt_type           new_count;

   assign entry = entry_type'(rd_data);

   isms_ram #(
      .DATA_W (ENTRY_W),
      .DEPTH  (MAX_INTERVALS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   isms_cmp u_cmp (
      .entry  (entry),
      .b_key  (b_ff),
      .e_key  (e_ff),
      .nb_key (nb_ff),
      .ne_key (ne_ff),
      .flags  (flags)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign at_end     = (p_ff == count_ff);
   assign absorb_now = !at_end && flags.lo_le_e && (absorb_ff || flags.hi_ge_b);
   assign new_count  = count_ff - k_ff + cnt_type'(1);
   assign rsp_load   = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      b_in      = b_ff;
      e_in      = e_ff;
      nb_in     = nb_ff;
      ne_in     = ne_ff;
      p_in      = p_ff;
      k_in      = k_ff;
      i_in      = i_ff;
      s_in      = s_ff;
      absorb_in = absorb_ff;
      answer_in = answer_ff;
      status_in = status_ff;
      count_in  = count_ff;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = rd_data;
      rd_addr   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in   = req_data.kind;
               b_in      = to_key(req_data.range_begin);
               e_in      = to_key(req_data.range_end);
               nb_in     = to_key(req_data.range_begin);
               ne_in     = to_key(req_data.range_end);
               p_in      = '0;
               k_in      = '0;
               absorb_in = 1'b0;
               answer_in = 1'b0;
               status_in = 1'b0;
               if (req_data.kind == KIND_INCLUDE || req_data.kind == KIND_INTERSECTS ||
                   req_data.kind == KIND_CONTAINS) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end

         ST_SCAN: begin
            rd_addr = idx_type'(p_ff + cnt_type'(1));
            unique case (kind_ff)
               KIND_INTERSECTS: begin
                  if (at_end || !flags.lo_le_e) begin
                     state_in = ST_RESP;
                  end else if (flags.hi_ge_b) begin
                     answer_in = 1'b1;
                     state_in  = ST_RESP;
                  end else begin
                     p_in = p_ff + cnt_type'(1);
                  end
               end
               KIND_CONTAINS: begin
                  if (at_end || !flags.lo_le_b) begin
                     state_in = ST_RESP;
                  end else if (flags.hi_ge_e) begin
                     answer_in = 1'b1;
                     state_in  = ST_RESP;
                  end else begin
                     p_in = p_ff + cnt_type'(1);
                  end
               end
               default: begin
                  if (absorb_now) begin
                     nb_in     = flags.lo_lt_nb ? entry.lo : nb_ff;
                     ne_in     = flags.hi_gt_ne ? entry.hi : ne_ff;
                     k_in      = k_ff + cnt_type'(1);
                     absorb_in = 1'b1;
                     p_in      = p_ff + cnt_type'(1);
                  end else if (!at_end && !absorb_ff && !flags.hi_ge_b) begin
                     p_in = p_ff + cnt_type'(1);
                  end else begin
                     i_in = p_ff - k_ff;
                     if (k_ff != '0) begin
                        s_in     = p_ff;
                        state_in = ST_PLACE;
                     end else if (count_ff == cnt_type'(MAX_INTERVALS)) begin
                        status_in = 1'b1;
                        state_in  = ST_RESP;
                     end else if (count_ff > p_ff) begin
                        s_in     = count_ff - cnt_type'(1);
                        state_in = ST_SHIFT_PREP;
                     end else begin
                        state_in = ST_PLACE;
                     end
                  end
               end
            endcase
         end

         ST_SHIFT_PREP: begin
            rd_addr  = idx_type'(s_ff);
            state_in = ST_SHIFT;
         end

         ST_SHIFT: begin
            rd_addr = idx_type'(s_ff - cnt_type'(1));
            wr_en   = 1'b1;
            wr_addr = idx_type'(s_ff + cnt_type'(1));
            if (s_ff == i_ff) begin
               state_in = ST_PLACE;
            end else begin
               s_in = s_ff - cnt_type'(1);
            end
         end

         ST_PLACE: begin
            rd_addr = idx_type'(s_ff);
            wr_en   = 1'b1;
            wr_addr = idx_type'(i_ff);
            wr_data = {nb_ff, ne_ff};
            if (k_ff != '0 && s_ff < count_ff) begin
               state_in = ST_COPY;
            end else begin
               state_in = ST_RESP;
            end
         end

         ST_COPY: begin
            rd_addr = idx_type'(s_ff + cnt_type'(1));
            wr_en   = 1'b1;
            wr_addr = idx_type'(s_ff - k_ff + cnt_type'(1));
            if (s_ff + cnt_type'(1) == count_ff) begin
               state_in = ST_RESP;
            end else begin
               s_in = s_ff + cnt_type'(1);
            end
         end

         ST_RESP: begin
            if (rsp_load) begin
               if (kind_ff == KIND_INCLUDE && !status_ff) begin
                  count_in = new_count;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (rsp_load) begin
         rsp_data_in.answer = answer_ff;
         rsp_data_in.status = status_ff;
         if (kind_ff == KIND_INCLUDE && !status_ff) begin
            rsp_data_in.entries_used = USED_W'(new_count);
         end else begin
            rsp_data_in.entries_used = USED_W'(count_ff);
         end
      end
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      b_ff        <= b_in;
      e_ff        <= e_in;
      nb_ff       <= nb_in;
      ne_ff       <= ne_in;
      p_ff        <= p_in;
      k_ff        <= k_in;
      i_ff        <= i_in;
      s_ff        <= s_in;
      absorb_ff   <= absorb_in;
      answer_ff   <= answer_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ISMS_ASSERT_IMPLY(a_scan_in_range, clock, reset, state_ff == ST_SCAN, p_ff <= count_ff)
   `ISMS_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1,
                      count_ff <= cnt_type'(MAX_INTERVALS))
   `ISMS_ASSERT_NEXT(a_drop_when_full, clock, reset, rsp_load && status_ff,
                     rsp_data_ff.entries_used == USED_W'(MAX_INTERVALS) && !rsp_data_ff.answer)
   `ISMS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready,
                     state_ff != ST_IDLE)

endmodule

// ----- design/isms_ram.sv -----
// -----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered read data.
// -----------------------------------------------------------------------------
module isms_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/isms_cmp.sv -----
// -----------------------------------------------------------------------------
// Interval set merge table compare unit
// Orders one stored entry against the request range and the merged range.
// -----------------------------------------------------------------------------
module isms_cmp import isms_pkg::*; (
   input  entry_type     entry,
   input  key_type       b_key,
   input  key_type       e_key,
   input  key_type       nb_key,
   input  key_type       ne_key,
   output cmp_flags_type flags
);

   always_comb begin
      flags.lo_le_e  = entry.lo <= e_key;
      flags.lo_le_b  = entry.lo <= b_key;
      flags.hi_ge_b  = entry.hi >= b_key;
      flags.hi_ge_e  = entry.hi >= e_key;
      flags.lo_lt_nb = entry.lo < nb_key;
      flags.hi_gt_ne = entry.hi > ne_key;
   end

endmodule

// ----- tb/sv/interval_set_merge_table_checker.sv -----
// -----------------------------------------------------------------------------
// Interval set merge table checker
// Watches both channels, keeps a shadow copy of the interval table, predicts
// the response to every accepted request and compares each field of the
// responses in order. Reports failures, outstanding, merges, drops, peak fill.
// -----------------------------------------------------------------------------
module interval_set_merge_table_checker import isms_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      answers_outstanding,
   output int      merge_count,
   output int      drop_count,
   output int      peak_fill
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   logic signed [FIELD_W-1:0] lo_tab [MAX_INTERVALS];
   logic signed [FIELD_W-1:0] hi_tab [MAX_INTERVALS];
   int                        stored;
   rsp_type                   expected_answers [$];

   function automatic rsp_type merge_or_query(input req_type r);
      rsp_type                   o;
      logic signed [FIELD_W-1:0] b, e, nb, ne;
      int                        i, k, j;
      o  = '0;
      b  = r.range_begin;
      e  = r.range_end;
      nb = b;
      ne = e;
      i  = 0;
      k  = 0;
      case (r.kind)
         KIND_INCLUDE: begin
            while (i < stored && hi_tab[i] < b) i++;
            while (i + k < stored && lo_tab[i + k] <= e) begin
               if (lo_tab[i + k] < nb) nb = lo_tab[i + k];
               if (hi_tab[i + k] > ne) ne = hi_tab[i + k];
               k++;
            end
            if (k == 0) begin
               if (stored >= MAX_INTERVALS) begin
                  o.status = 1'b1;
               end else begin
                  for (j = stored; j > i; j--) begin
                     lo_tab[j] = lo_tab[j - 1];
                     hi_tab[j] = hi_tab[j - 1];
                  end
                  lo_tab[i] = nb;
                  hi_tab[i] = ne;
                  stored++;
               end
            end else begin
               merge_count++;
               lo_tab[i] = nb;
               hi_tab[i] = ne;
               for (j = i + k; j < stored; j++) begin
                  lo_tab[j - k + 1] = lo_tab[j];
                  hi_tab[j - k + 1] = hi_tab[j];
               end
               stored = stored - k + 1;
            end
         end
         KIND_INTERSECTS: begin
            while (i < stored && lo_tab[i] <= e) begin
               if (hi_tab[i] >= b) o.answer = 1'b1;
               i++;
            end
         end
         KIND_CONTAINS: begin
            while (i < stored && lo_tab[i] <= b) begin
               if (hi_tab[i] >= e) o.answer = 1'b1;
               i++;
            end
         end
         default: begin
         end
      endcase
      o.entries_used = USED_W'(stored);
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         stored      = 0;
         fail_count  = 0;
         merge_count = 0;
         drop_count  = 0;
         peak_fill   = 0;
         expected_answers.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_answers.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("%0t: response with none outstanding: answer %0b status %0b used %0d",
                           $realtime, rsp_data.answer, rsp_data.status,
                           rsp_data.entries_used);
            end else begin
               want = expected_answers.pop_front();
               if (rsp_data.answer !== want.answer || rsp_data.status !== want.status ||
                   rsp_data.entries_used !== want.entries_used) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT)
                     $display("%0t: mismatch: expected answer %0b status %0b used %0d, got %0b %0b %0d",
                              $realtime, want.answer, want.status, want.entries_used,
                              rsp_data.answer, rsp_data.status, rsp_data.entries_used);
               end
            end
         end
         if (req_valid && req_ready) begin
            want = merge_or_query(req_data);
            expected_answers.push_back(want);
            if (want.status) drop_count++;
            if (stored > peak_fill) peak_fill = stored;
         end
      end
      answers_outstanding = expected_answers.size();
   end

endmodule

// ----- tb/sv/interval_set_merge_table_tb.sv -----
// -----------------------------------------------------------------------------
// Interval set merge table testbench
// Drives directed edge cases, then windows of random includes, queries and
// unknown kinds under four handshake profiles and one long response hold;
// the checker beside the block predicts and compares every response.
// -----------------------------------------------------------------------------
module interval_set_merge_table_tb import isms_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [KIND_W-1:0]         KIND_UNKNOWN   = 2'd3;
   localparam logic signed [FIELD_W-1:0] COORD_MIN      = 32'sh8000_0000;
   localparam logic signed [FIELD_W-1:0] COORD_MAX      = 32'sh7fff_ffff;
   localparam int                        WINDOW_SPAN    = 600;
   localparam int                        PHASE_ITEMS    = 338;
   localparam int                        HOLD_CYCLES    = 300;
   localparam int                        WATCHDOG_LIMIT = 5000;
   localparam int                        DRAIN_CYCLES   = 60;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   int fail_count;
   int answers_outstanding;
   int merge_count;
   int drop_count;
   int peak_fill;

   int                        send_idle_pct;
   int                        recv_stall_pct;
   bit                        hold_request;
   int                        sent_count;
   logic signed [FIELD_W-1:0] window_base;

   interval_set_merge_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   interval_set_merge_table_checker checker_inst (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data            (req_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_data            (rsp_data),
      .fail_count          (fail_count),
      .answers_outstanding (answers_outstanding),
      .merge_count         (merge_count),
      .drop_count          (drop_count),
      .peak_fill           (peak_fill)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic req_type pack_request(input logic [KIND_W-1:0] kind,
                                            input logic signed [FIELD_W-1:0] b,
                                            input logic signed [FIELD_W-1:0] e);
      req_type r;
      r.kind        = kind;
      r.range_begin = b;
      r.range_end   = e;
      return r;
   endfunction

   function automatic req_type random_request();
      int                        roll, shape;
      logic signed [FIELD_W-1:0] b, e;
      roll  = $urandom_range(99);
      shape = $urandom_range(99);
      b     = window_base + $urandom_range(WINDOW_SPAN);
      if (roll < 45) begin
         if (shape < 3) begin
            b = window_base - 10;
            e = window_base + WINDOW_SPAN + 200;
         end else if (shape < 8) begin
            e = b - $urandom_range(20, 1);
         end else if (shape < 23) begin
            e = b + $urandom_range(150);
         end else begin
            e = b + $urandom_range(12);
         end
         return pack_request(KIND_INCLUDE, b, e);
      end
      if (roll >= 95) return pack_request(KIND_UNKNOWN, $urandom, $urandom);
      if (shape < 10) b = $urandom;
      e = (shape >= 10 && shape < 15) ? b - $urandom_range(8, 1) : b + $urandom_range(8);
      if (shape >= 95) e = $urandom;
      return pack_request((roll < 70) ? KIND_INTERSECTS : KIND_CONTAINS, b, e);
   endfunction

   task automatic send_request(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
      @(negedge clock);
   endtask

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int                        phase, n;
      int                        idle_pct  [4];
      int                        stall_pct [4];
      logic signed [FIELD_W-1:0] bases     [4];
      idle_pct  = '{0, 76, 0, 34};
      stall_pct = '{0, 0, 76, 34};
      bases     = '{-300, COORD_MIN + 1000, COORD_MAX - 2000, 40_000_000};
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_request   = 1'b0;
      sent_count     = 0;
      window_base    = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_request(pack_request(KIND_INTERSECTS, COORD_MIN, COORD_MAX));
      send_request(pack_request(KIND_INCLUDE, COORD_MIN, COORD_MIN));
      send_request(pack_request(KIND_INCLUDE, COORD_MAX, COORD_MAX));
      send_request(pack_request(KIND_INCLUDE, -5, 5));
      send_request(pack_request(KIND_CONTAINS, -5, 5));
      send_request(pack_request(KIND_CONTAINS, -6, 5));
      send_request(pack_request(KIND_INCLUDE, 20, 15));
      send_request(pack_request(KIND_INTERSECTS, 10, -10));
      send_request(pack_request(KIND_UNKNOWN, COORD_MAX, COORD_MIN));
      send_request(pack_request(KIND_INCLUDE, -100, 100));
      // fill the table with separated intervals until includes drop
      for (n = 1; n <= 16; n++)
         send_request(pack_request(KIND_INCLUDE, n * 1000, n * 1000 + 10));
      send_request(pack_request(KIND_INCLUDE, 1005, 3005));
      send_request(pack_request(KIND_INCLUDE, 0, 20000));

      for (phase = 0; phase < 4; phase++) begin
         send_idle_pct  = idle_pct[phase];
         recv_stall_pct = stall_pct[phase];
         window_base    = bases[phase];
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 0 && n == 100) hold_request = 1'b1;
            send_request(random_request());
         end
      end

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_request(pack_request(KIND_INCLUDE, COORD_MIN, COORD_MAX));
      send_request(pack_request(KIND_CONTAINS, COORD_MIN, COORD_MAX));
      req_valid <= 1'b0;

      while (answers_outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Sent %0d requests over four handshake profiles plus a long response hold;",
               sent_count);
      $display("%0d includes merged entries, %0d dropped on a full table, peak fill %0d.",
               merge_count, drop_count, peak_fill);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
